// ----- rtl/core/mvlt_pkg.sv -----
// ----------------------------------------------------------------------------
// mvlt_pkg
// Shared widths, operation and status codes for the MAC/VLAN learning table.
// ----------------------------------------------------------------------------
package mvlt_pkg;

  // fixed field widths
  localparam int MAC_W      = 48;
  localparam int LLID_W     = 13;
  localparam int PORT_W     = 4;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;
  localparam int AGING_W    = 16;
  localparam int LIMIT_W    = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // list results per request, and a counter that can hold that count
  localparam int MAX_RESULTS = 16;
  localparam int KCNT_W      = 5;

  // reset value of the aging time register
  localparam logic [AGING_W-1:0] AGING_RESET = 16'd10;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_AGING_TIME  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LIMIT = 1'b1;

  // request codes
  typedef enum logic [OP_W-1:0] {
    OP_LEARN  = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_LIST   = 2'd2,
    OP_TICK   = 2'd3
  } op_t;

  // learn outcome codes
  typedef enum logic [STATUS_W-1:0] {
    ST_REFRESHED = 2'd0,
    ST_INSERTED  = 2'd1,
    ST_PURGED    = 2'd2,
    ST_EVICTED   = 2'd3
  } status_t;

  // compare flags from the age unit
  typedef struct packed {
    logic aged;   // age at or past the aging time
    logic older;  // age strictly greater than the running best
  } age_flags_t;

endpackage

// ----- rtl/core/mvlt_store.sv -----
// ----------------------------------------------------------------------------
// mvlt_store
// Slot storage: mac, link id, port and time stamp, one write and one
// registered read port.
// ----------------------------------------------------------------------------
module mvlt_store #(
  parameter int TABLE_DEPTH = 16,
  parameter int TIME_BITS   = 32
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [$clog2(TABLE_DEPTH)-1:0]    wr_addr,
  input  logic [mvlt_pkg::MAC_W-1:0]        wr_mac,
  input  logic [mvlt_pkg::LLID_W-1:0]       wr_llid,
  input  logic [mvlt_pkg::PORT_W-1:0]       wr_port,
  input  logic [TIME_BITS-1:0]              wr_time,
  input  logic                              rd_en,
  input  logic [$clog2(TABLE_DEPTH)-1:0]    rd_addr,
  output logic [mvlt_pkg::MAC_W-1:0]        rd_mac,
  output logic [mvlt_pkg::LLID_W-1:0]       rd_llid,
  output logic [mvlt_pkg::PORT_W-1:0]       rd_port,
  output logic [TIME_BITS-1:0]              rd_time
);

  localparam int ENTRY_W = mvlt_pkg::MAC_W + mvlt_pkg::LLID_W + mvlt_pkg::PORT_W + TIME_BITS;

  logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_mac, wr_llid, wr_port, wr_time};
    end
  end

  // registered read, held while the reader stalls
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign {rd_mac, rd_llid, rd_port, rd_time} = rd_data_r;

endmodule

// ----- rtl/core/mvlt_age_unit.sv -----
// ----------------------------------------------------------------------------
// mvlt_age_unit
// Shared age subtractor with the aging and oldest-entry compares.
// ----------------------------------------------------------------------------
module mvlt_age_unit #(
  parameter int TIME_BITS = 32
) (
  input  logic [TIME_BITS-1:0]              time_now,
  input  logic [TIME_BITS-1:0]              slot_time,
  input  logic [mvlt_pkg::AGING_W-1:0]      aging_time,
  input  logic [TIME_BITS-1:0]              best_age,
  output logic [TIME_BITS-1:0]              age,
  output mvlt_pkg::age_flags_t              flags
);

  // age wraps modulo the counter width
  assign age = time_now - slot_time;

  assign flags.aged  = (age >= TIME_BITS'(aging_time));
  assign flags.older = (age > best_age);

endmodule

// ----- rtl/core/mac_vlan_learning_table.sv -----
// ----------------------------------------------------------------------------
// mac_vlan_learning_table
// Switch address table keyed by MAC and link id, with learning and aging.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_stall with op, mac, llid and port; results
//   leave on out_valid/out_stall. Learn and lookup give one result, list gives
//   one result per live entry with that MAC, at most MAX_RESULTS (or one miss
//   result); last marks the final one. A tick advances the time counter and
//   gives no result. Every other request walks all slots once, one slot per
//   cycle while no list result is held back, through the shared age unit and
//   the single read port of the slot store, and in_stall stays high meanwhile.
//   Results go through an output register, so a finished result may wait
//   while the next request is taken. A stalled receiver holds a list walk
//   whenever a further result is found while an earlier one is held and the
//   output register is still full. The user must write aging_time and
//   table_limit through cfg_wr_en/cfg_index/cfg_data only while the block is
//   idle; the block itself does not enforce this. Reset clears all slot valid
//   bits, the time counter and the registers to their defaults; the block is
//   ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module mac_vlan_learning_table #(
  parameter int TABLE_DEPTH = 16,
  parameter int TIME_BITS   = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // request channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [mvlt_pkg::OP_W-1:0]             in_op,
  input  logic [mvlt_pkg::MAC_W-1:0]            in_mac,
  input  logic signed [mvlt_pkg::LLID_W-1:0]    in_llid,
  input  logic [mvlt_pkg::PORT_W-1:0]           in_port,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_found,
  output logic [mvlt_pkg::PORT_W-1:0]           out_port_out,
  output logic signed [mvlt_pkg::LLID_W-1:0]    out_llid_out,
  output logic [mvlt_pkg::STATUS_W-1:0]         out_status,
  output logic                                  out_last,
  // configuration
  input  logic                                  cfg_wr_en,
  input  logic [mvlt_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mvlt_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int IDX_W    = $clog2(TABLE_DEPTH);
  localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
  localparam int MAC_W    = mvlt_pkg::MAC_W;
  localparam int LLID_W   = mvlt_pkg::LLID_W;
  localparam int PORT_W   = mvlt_pkg::PORT_W;
  localparam int AGING_W  = mvlt_pkg::AGING_W;
  localparam int LIMIT_W  = mvlt_pkg::LIMIT_W;
  localparam int KCNT_W   = mvlt_pkg::KCNT_W;
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [KCNT_W-1:0] K_MAX    = KCNT_W'(mvlt_pkg::MAX_RESULTS);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_FINISH = 4'b0100,
    S_RESP   = 4'b1000
  } state_t;

  // control registers
  state_t                      state_r, state_nxt;
  logic [AGING_W-1:0]          aging_r, aging_nxt;
  logic [LIMIT_W-1:0]          limit_r, limit_nxt;
  logic [TIME_BITS-1:0]        time_r, time_nxt;
  logic [TABLE_DEPTH-1:0]      valid_r, valid_nxt;
  logic                        issue_live_r, issue_live_nxt;
  logic                        ev_live_r, ev_live_nxt;
  logic                        hit_r, hit_nxt;
  logic                        free_live_r, free_live_nxt;
  logic                        aged_live_r, aged_live_nxt;
  logic                        best_live_r, best_live_nxt;
  logic                        pend_valid_r, pend_valid_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]            used_r, used_nxt;
  logic [CNT_W-1:0]            unaged_r, unaged_nxt;
  logic [KCNT_W-1:0]           kcnt_r, kcnt_nxt;

  // request and tracking payload
  mvlt_pkg::op_t               op_r, op_nxt;
  logic [MAC_W-1:0]            mac_r, mac_nxt;
  logic [LLID_W-1:0]           llid_r, llid_nxt;
  logic [PORT_W-1:0]           port_r, port_nxt;
  logic [IDX_W-1:0]            issue_idx_r, issue_idx_nxt;
  logic [IDX_W-1:0]            ev_idx_r, ev_idx_nxt;
  logic [IDX_W-1:0]            hit_idx_r, hit_idx_nxt;
  logic                        hit_aged_r, hit_aged_nxt;
  logic [PORT_W-1:0]           hit_port_r, hit_port_nxt;
  logic [LLID_W-1:0]           hit_llid_r, hit_llid_nxt;
  logic [IDX_W-1:0]            free_idx_r, free_idx_nxt;
  logic [IDX_W-1:0]            aged_idx_r, aged_idx_nxt;
  logic [IDX_W-1:0]            best_idx_r, best_idx_nxt;
  logic [TIME_BITS-1:0]        best_age_r, best_age_nxt;
  logic [TABLE_DEPTH-1:0]      aged_mask_r, aged_mask_nxt;
  logic                        pend_found_r, pend_found_nxt;
  logic [PORT_W-1:0]           pend_port_r, pend_port_nxt;
  logic [LLID_W-1:0]           pend_llid_r, pend_llid_nxt;
  logic [mvlt_pkg::STATUS_W-1:0] pend_status_r, pend_status_nxt;
  logic                        out_found_r, out_found_nxt;
  logic [PORT_W-1:0]           out_port_r, out_port_nxt;
  logic [LLID_W-1:0]           out_llid_r, out_llid_nxt;
  logic [mvlt_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic                        out_last_r, out_last_nxt;

  // store and age unit wiring
  logic                        wr_en;
  logic [IDX_W-1:0]            wr_addr;
  logic                        rd_en;
  logic [MAC_W-1:0]            rd_mac;
  logic [LLID_W-1:0]           rd_llid;
  logic [PORT_W-1:0]           rd_port;
  logic [TIME_BITS-1:0]        rd_time;
  logic [TIME_BITS-1:0]        age;
  mvlt_pkg::age_flags_t        flags;

  // walk and decision helpers
  logic                        out_free;
  logic                        ev_v;
  logic                        key_match;
  logic                        mac_match;
  logic                        list_emit;
  logic                        scan_hold;
  logic                        advance;
  logic [CNT_W-1:0]            lim_eff;
  logic                        need_purge;
  logic                        need_evict;
  logic [IDX_W-1:0]            ins_idx;
  logic                        ins_live;
  logic [TABLE_DEPTH-1:0]      clr_mask;
  mvlt_pkg::status_t           learn_status;

  mvlt_store #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_mac  (mac_r),
    .wr_llid (llid_r),
    .wr_port (port_r),
    .wr_time (time_r),
    .rd_en   (rd_en),
    .rd_addr (issue_idx_r),
    .rd_mac  (rd_mac),
    .rd_llid (rd_llid),
    .rd_port (rd_port),
    .rd_time (rd_time)
  );

  mvlt_age_unit #(
    .TIME_BITS (TIME_BITS)
  ) u_age (
    .time_now   (time_r),
    .slot_time  (rd_time),
    .aging_time (aging_r),
    .best_age   (best_age_r),
    .age        (age),
    .flags      (flags)
  );

  // handshake views
  assign in_stall     = (state_r != S_IDLE);
  assign out_free     = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_port_out = out_port_r;
  assign out_llid_out = out_llid_r;
  assign out_status   = out_status_r;
  assign out_last     = out_last_r;

  // slot under evaluation
  assign ev_v      = valid_r[ev_idx_r];
  assign key_match = (rd_mac == mac_r) && (rd_llid == llid_r);
  assign mac_match = (rd_mac == mac_r);
  assign list_emit = ev_live_r && (op_r == mvlt_pkg::OP_LIST) && ev_v && !flags.aged &&
                     mac_match && (kcnt_r < K_MAX);
  // a further list hit waits until the held one can leave
  assign scan_hold = list_emit && pend_valid_r && !out_free;
  assign advance   = (state_r == S_SCAN) && !scan_hold;
  assign rd_en     = advance && issue_live_r;

  // effective limit, saturated to the store depth; zero also gives the store depth
  always_comb begin
    if ((limit_r == '0) || (int'(limit_r) > TABLE_DEPTH)) begin
      lim_eff = CNT_W'(TABLE_DEPTH);
    end else begin
      lim_eff = CNT_W'(limit_r);
    end
  end

  // learn decision from the walk results
  always_comb begin
    need_purge = (used_r >= lim_eff);
    need_evict = need_purge && (unaged_r >= lim_eff);
    ins_idx    = free_idx_r;
    ins_live   = free_live_r;
    if (need_purge && aged_live_r && (!ins_live || (aged_idx_r < ins_idx))) begin
      ins_idx  = aged_idx_r;
      ins_live = 1'b1;
    end
    if (need_evict && (!ins_live || (best_idx_r < ins_idx))) begin
      ins_idx  = best_idx_r;
      ins_live = 1'b1;
    end
    clr_mask = need_purge ? aged_mask_r : '0;
    if (need_evict) begin
      clr_mask[best_idx_r] = 1'b1;
    end
    if (need_evict) begin
      learn_status = mvlt_pkg::ST_EVICTED;
    end else if (need_purge) begin
      learn_status = mvlt_pkg::ST_PURGED;
    end else begin
      learn_status = mvlt_pkg::ST_INSERTED;
    end
  end

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    aging_nxt       = aging_r;
    limit_nxt       = limit_r;
    time_nxt        = time_r;
    valid_nxt       = valid_r;
    issue_live_nxt  = issue_live_r;
    ev_live_nxt     = ev_live_r;
    hit_nxt         = hit_r;
    free_live_nxt   = free_live_r;
    aged_live_nxt   = aged_live_r;
    best_live_nxt   = best_live_r;
    pend_valid_nxt  = pend_valid_r;
    used_nxt        = used_r;
    unaged_nxt      = unaged_r;
    kcnt_nxt        = kcnt_r;
    op_nxt          = op_r;
    mac_nxt         = mac_r;
    llid_nxt        = llid_r;
    port_nxt        = port_r;
    issue_idx_nxt   = issue_idx_r;
    ev_idx_nxt      = ev_idx_r;
    hit_idx_nxt     = hit_idx_r;
    hit_aged_nxt    = hit_aged_r;
    hit_port_nxt    = hit_port_r;
    hit_llid_nxt    = hit_llid_r;
    free_idx_nxt    = free_idx_r;
    aged_idx_nxt    = aged_idx_r;
    best_idx_nxt    = best_idx_r;
    best_age_nxt    = best_age_r;
    aged_mask_nxt   = aged_mask_r;
    pend_found_nxt  = pend_found_r;
    pend_port_nxt   = pend_port_r;
    pend_llid_nxt   = pend_llid_r;
    pend_status_nxt = pend_status_r;
    out_found_nxt   = out_found_r;
    out_port_nxt    = out_port_r;
    out_llid_nxt    = out_llid_r;
    out_status_nxt  = out_status_r;
    out_last_nxt    = out_last_r;
    out_valid_nxt   = out_valid_r && out_stall;
    wr_en           = 1'b0;
    wr_addr         = ins_idx;

    // configuration writes
    if (cfg_wr_en) begin
      case (cfg_index)
        mvlt_pkg::CFG_AGING_TIME:  aging_nxt = cfg_data;
        mvlt_pkg::CFG_TABLE_LIMIT: limit_nxt = cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_op == mvlt_pkg::OP_TICK) begin
            time_nxt = time_r + TIME_BITS'(1);
          end else begin
            op_nxt         = mvlt_pkg::op_t'(in_op);
            mac_nxt        = in_mac;
            llid_nxt       = in_llid;
            port_nxt       = in_port;
            issue_idx_nxt  = '0;
            issue_live_nxt = 1'b1;
            ev_live_nxt    = 1'b0;
            hit_nxt        = 1'b0;
            free_live_nxt  = 1'b0;
            aged_live_nxt  = 1'b0;
            best_live_nxt  = 1'b0;
            best_age_nxt   = '0;
            aged_mask_nxt  = '0;
            used_nxt       = '0;
            unaged_nxt     = '0;
            kcnt_nxt       = '0;
            pend_valid_nxt = 1'b0;
            state_nxt      = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (advance) begin
          // issue the next slot read
          ev_live_nxt = issue_live_r;
          ev_idx_nxt  = issue_idx_r;
          if (issue_live_r) begin
            issue_idx_nxt = issue_idx_r + IDX_W'(1);
            if (issue_idx_r == LAST_IDX) begin
              issue_live_nxt = 1'b0;
            end
          end
          // evaluate the slot whose data has arrived
          if (ev_live_r) begin
            case (op_r)
              mvlt_pkg::OP_LEARN: begin
                if (ev_v) begin
                  used_nxt = used_r + CNT_W'(1);
                  if (key_match && !hit_r) begin
                    hit_nxt     = 1'b1;
                    hit_idx_nxt = ev_idx_r;
                  end
                  if (flags.aged) begin
                    aged_mask_nxt[ev_idx_r] = 1'b1;
                    if (!aged_live_r) begin
                      aged_live_nxt = 1'b1;
                      aged_idx_nxt  = ev_idx_r;
                    end
                  end else begin
                    unaged_nxt = unaged_r + CNT_W'(1);
                    if (!best_live_r || flags.older) begin
                      best_live_nxt = 1'b1;
                      best_idx_nxt  = ev_idx_r;
                      best_age_nxt  = age;
                    end
                  end
                end else if (!free_live_r) begin
                  free_live_nxt = 1'b1;
                  free_idx_nxt  = ev_idx_r;
                end
              end
              mvlt_pkg::OP_LOOKUP: begin
                if (ev_v && key_match && !hit_r) begin
                  hit_nxt      = 1'b1;
                  hit_idx_nxt  = ev_idx_r;
                  hit_aged_nxt = flags.aged;
                  hit_port_nxt = rd_port;
                  hit_llid_nxt = rd_llid;
                end
              end
              mvlt_pkg::OP_LIST: begin
                if (ev_v && flags.aged) begin
                  valid_nxt[ev_idx_r] = 1'b0;
                end
                if (list_emit) begin
                  // the held hit is not the final one, send it on
                  if (pend_valid_r) begin
                    out_valid_nxt  = 1'b1;
                    out_found_nxt  = pend_found_r;
                    out_port_nxt   = pend_port_r;
                    out_llid_nxt   = pend_llid_r;
                    out_status_nxt = pend_status_r;
                    out_last_nxt   = 1'b0;
                  end
                  pend_valid_nxt  = 1'b1;
                  pend_found_nxt  = 1'b1;
                  pend_port_nxt   = rd_port;
                  pend_llid_nxt   = rd_llid;
                  pend_status_nxt = mvlt_pkg::ST_REFRESHED;
                  kcnt_nxt        = kcnt_r + KCNT_W'(1);
                end
              end
              default: ;
            endcase
            if (ev_idx_r == LAST_IDX) begin
              state_nxt = S_FINISH;
            end
          end
        end
      end

      S_FINISH: begin
        case (op_r)
          mvlt_pkg::OP_LEARN: begin
            wr_en = 1'b1;
            if (hit_r) begin
              wr_addr         = hit_idx_r;
              pend_status_nxt = mvlt_pkg::ST_REFRESHED;
            end else begin
              wr_addr              = ins_idx;
              valid_nxt            = valid_r & ~clr_mask;
              valid_nxt[ins_idx]   = 1'b1;
              pend_status_nxt      = learn_status;
            end
            pend_found_nxt = 1'b0;
            pend_port_nxt  = '0;
            pend_llid_nxt  = '0;
          end
          mvlt_pkg::OP_LOOKUP: begin
            if (hit_r && hit_aged_r) begin
              valid_nxt[hit_idx_r] = 1'b0;
            end
            pend_found_nxt  = hit_r && !hit_aged_r;
            pend_port_nxt   = (hit_r && !hit_aged_r) ? hit_port_r : '0;
            pend_llid_nxt   = (hit_r && !hit_aged_r) ? hit_llid_r : '0;
            pend_status_nxt = mvlt_pkg::ST_REFRESHED;
          end
          mvlt_pkg::OP_LIST: begin
            // no live match: one miss beat
            if (!pend_valid_r) begin
              pend_found_nxt  = 1'b0;
              pend_port_nxt   = '0;
              pend_llid_nxt   = '0;
              pend_status_nxt = mvlt_pkg::ST_REFRESHED;
            end
          end
          default: ;
        endcase
        state_nxt = S_RESP;
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_found_nxt  = pend_found_r;
          out_port_nxt   = pend_port_r;
          out_llid_nxt   = pend_llid_r;
          out_status_nxt = pend_status_r;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      aging_r      <= mvlt_pkg::AGING_RESET;
      limit_r      <= '0;
      time_r       <= '0;
      valid_r      <= '0;
      issue_live_r <= 1'b0;
      ev_live_r    <= 1'b0;
      hit_r        <= 1'b0;
      free_live_r  <= 1'b0;
      aged_live_r  <= 1'b0;
      best_live_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      used_r       <= '0;
      unaged_r     <= '0;
      kcnt_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      aging_r      <= aging_nxt;
      limit_r      <= limit_nxt;
      time_r       <= time_nxt;
      valid_r      <= valid_nxt;
      issue_live_r <= issue_live_nxt;
      ev_live_r    <= ev_live_nxt;
      hit_r        <= hit_nxt;
      free_live_r  <= free_live_nxt;
      aged_live_r  <= aged_live_nxt;
      best_live_r  <= best_live_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      used_r       <= used_nxt;
      unaged_r     <= unaged_nxt;
      kcnt_r       <= kcnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    mac_r         <= mac_nxt;
    llid_r        <= llid_nxt;
    port_r        <= port_nxt;
    issue_idx_r   <= issue_idx_nxt;
    ev_idx_r      <= ev_idx_nxt;
    hit_idx_r     <= hit_idx_nxt;
    hit_aged_r    <= hit_aged_nxt;
    hit_port_r    <= hit_port_nxt;
    hit_llid_r    <= hit_llid_nxt;
    free_idx_r    <= free_idx_nxt;
    aged_idx_r    <= aged_idx_nxt;
    best_idx_r    <= best_idx_nxt;
    best_age_r    <= best_age_nxt;
    aged_mask_r   <= aged_mask_nxt;
    pend_found_r  <= pend_found_nxt;
    pend_port_r   <= pend_port_nxt;
    pend_llid_r   <= pend_llid_nxt;
    pend_status_r <= pend_status_nxt;
    out_found_r   <= out_found_nxt;
    out_port_r    <= out_port_nxt;
    out_llid_r    <= out_llid_nxt;
    out_status_r  <= out_status_nxt;
    out_last_r    <= out_last_nxt;
  end

endmodule

// ----- rtl/core/mvlt_checker.sv -----
// ----------------------------------------------------------------------------
// mvlt_checker
// Port-level checks for the learning table, bound to the top level.
// ----------------------------------------------------------------------------
module mvlt_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic [mvlt_pkg::OP_W-1:0]         in_op,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic                              out_found,
  input logic [mvlt_pkg::PORT_W-1:0]       out_port_out,
  input logic [mvlt_pkg::LLID_W-1:0]       out_llid_out,
  input logic [mvlt_pkg::STATUS_W-1:0]     out_status,
  input logic                              out_last
);

  // a stalled result beat holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_found) && $stable(out_port_out) &&
    $stable(out_llid_out) && $stable(out_status) && $stable(out_last))
    else $error("stalled result beat changed");

  // no result beat right after reset
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat after reset");

  // any table request blocks the next one while the walk runs
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_op != mvlt_pkg::OP_TICK) |=> in_stall)
    else $error("request taken during table walk");

  // a hit never carries a learn status
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> (out_status == mvlt_pkg::ST_REFRESHED))
    else $error("hit beat with learn status");

  // a miss always ends its request
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_last)
    else $error("miss beat not marked last");

endmodule

bind mac_vlan_learning_table mvlt_checker u_mvlt_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .in_op        (in_op),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_found    (out_found),
  .out_port_out (out_port_out),
  .out_llid_out (out_llid_out),
  .out_status   (out_status),
  .out_last     (out_last)
);
